// ===== design/gic_pkg.sv =====
// ----------------------------------------------------------------------------
// gic_pkg
// Shared widths, reset values and register indexes of the gamepad input
// conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

   localparam int AXIS_BITS_DEFAULT = 16;

   localparam int BUTTON_W  = 16;
   localparam int AXIS_W    = 16;
   localparam int TRIGGER_W = 8;
   localparam int CSR_W     = 16;

   localparam logic [CSR_W-1:0] DEAD_ZONE_RESET = 16'd13107;

   typedef logic [BUTTON_W-1:0]         buttons_type;
   typedef logic signed [AXIS_W-1:0]    axis_type;
   typedef logic [TRIGGER_W-1:0]        trigger_type;

   typedef enum logic [0:0] {
      CSR_DEAD_ZONE = 1'b0,
      CSR_INVERT_LY = 1'b1
   } csr_index_type;

endpackage

// ===== design/gic_req_if.sv =====
// ----------------------------------------------------------------------------
// gic_req_if
// Frame channel: one raw controller frame per beat.
// ----------------------------------------------------------------------------
interface gic_req_if;
   import gic_pkg::*;

   logic        valid;
   logic        ready;
   buttons_type buttons;
   axis_type    left_x;
   axis_type    left_y;
   axis_type    right_x;
   axis_type    right_y;
   trigger_type left_trigger;
   trigger_type right_trigger;

   modport source (
      output valid, buttons, left_x, left_y, right_x, right_y,
             left_trigger, right_trigger,
      input  ready
   );

   modport sink (
      input  valid, buttons, left_x, left_y, right_x, right_y,
             left_trigger, right_trigger,
      output ready
   );

endinterface

// ===== design/gic_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gic_rsp_if
// Result channel: one conditioned frame per beat.
// ----------------------------------------------------------------------------
interface gic_rsp_if;
   import gic_pkg::*;

   logic        valid;
   logic        ready;
   buttons_type pressed_edges;
   buttons_type released_edges;
   buttons_type held_buttons;
   axis_type    left_out_x;
   axis_type    left_out_y;
   axis_type    right_out_x;
   axis_type    right_out_y;
   trigger_type left_trigger_level;
   trigger_type right_trigger_level;

   modport source (
      output valid, pressed_edges, released_edges, held_buttons,
             left_out_x, left_out_y, right_out_x, right_out_y,
             left_trigger_level, right_trigger_level,
      input  ready
   );

   modport sink (
      input  valid, pressed_edges, released_edges, held_buttons,
             left_out_x, left_out_y, right_out_x, right_out_y,
             left_trigger_level, right_trigger_level,
      output ready
   );

endinterface

// ===== design/gamepad_input_conditioner.sv =====
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// Button edge detection, scaled radial stick dead zone and linear trigger
// dead zone, worked out on one shared multiplier and one shared subtractor.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  - raw frame beats (buttons, four axes, two triggers).
//   rsp_chan  - conditioned frame beats, exactly one per request beat.
//   csr_*     - register writes: dead zone (Q0.16) and left Y inversion.
// A frame is taken only when the sequencer is idle; its result reaches the
// output register through these steps in order: the dead zone is squared;
// per stick, the axes are squared and summed, a bit-pair square root runs,
// scale and divisor are formed, then per axis a multiply and a restoring
// divide run; each trigger runs a restoring divide, and a last step loads
// the output register. A new frame is taken only after the sequencer has
// returned to idle. The root and divide loops, one bit per cycle on the
// shared subtractor, dominate. Sticks or triggers inside the dead zone skip their loops.
// The result sits in an output register; a new frame is accepted while it
// waits, and the sequencer holds at its end until the register is free.
// Reset (synchronous) clears the previous button word to zero and loads
// the registers with dead zone 13107 and no inversion.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner #(
   parameter int AXIS_BITS = gic_pkg::AXIS_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   gic_req_if.sink                  req_chan,
   gic_rsp_if.source                rsp_chan,
   input  logic                     csr_wr_en,
   input  gic_pkg::csr_index_type   csr_index,
   input  logic [gic_pkg::CSR_W-1:0] csr_wdata
);
   import gic_pkg::*;

   localparam logic [15:0] AXIS_FS = 16'((1 << (AXIS_BITS - 1)) - 1);

   typedef enum logic [14:0] {
      ST_IDLE  = 15'b000000000000001,
      ST_DZ    = 15'b000000000000010,
      ST_DZSQ  = 15'b000000000000100,
      ST_SQX   = 15'b000000000001000,
      ST_SQY   = 15'b000000000010000,
      ST_SUM   = 15'b000000000100000,
      ST_SQRT  = 15'b000000001000000,
      ST_SCALE = 15'b000000010000000,
      ST_DEN   = 15'b000000100000000,
      ST_MLO   = 15'b000001000000000,
      ST_MHI   = 15'b000010000000000,
      ST_NUM   = 15'b000100000000000,
      ST_DIV   = 15'b001000000000000,
      ST_TRG   = 15'b010000000000000,
      ST_DONE  = 15'b100000000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  job_ff, job_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] prod_ff, prod_in;
   logic [30:0] thr_ff, thr_in;
   logic [61:0] thrsq_ff, thrsq_in;
   logic [39:0] acc_ff, acc_in;
   logic [59:0] rem_ff, rem_in;
   logic [47:0] root_ff, root_in;
   logic [16:0] q_ff, q_in;
   logic [39:0] scale_ff, scale_in;
   logic [41:0] dvs_ff, dvs_in;
   logic [15:0] res_ff [6];
   logic [15:0] res_in [6];

   buttons_type prev_ff, prev_in;
   buttons_type prs_ff, prs_in, rel_ff, rel_in, held_ff, held_in;
   axis_type    lx_ff, lx_in, ly_ff, ly_in, rx_ff, rx_in, ry_ff, ry_in;
   trigger_type lt_ff, lt_in, rt_ff, rt_in;

   logic [15:0] dz_ff, dz_in;
   logic        inv_ff, inv_in;

   logic        rsp_valid_ff, rsp_valid_in;
   buttons_type o_prs_ff, o_prs_in, o_rel_ff, o_rel_in, o_held_ff, o_held_in;
   axis_type    o_lx_ff, o_lx_in, o_ly_ff, o_ly_in, o_rx_ff, o_rx_in, o_ry_ff, o_ry_in;
   trigger_type o_lt_ff, o_lt_in, o_rt_ff, o_rt_in;

   // shared units
   logic [31:0] mul_a, mul_b;
   logic [59:0] sub_a, sub_b;
   logic [60:0] diff;
   logic        ge;

   // axis selection
   logic [15:0] stick_xr, stick_yr, cur_raw;
   logic [15:0] mag_x, mag_y, cur_mag;
   logic        cur_neg;

   // scratch
   logic [31:0] sumsq;
   logic [47:0] bitv;
   logic [23:0] r;
   logic [39:0] lhs, off, cap, sc;
   logic [59:0] num;
   logic [16:0] qfin;
   logic [15:0] qc;
   logic [23:0] tt, dz255;
   logic [16:0] dzc;
   trigger_type tsel;

   function automatic logic [15:0] axis_mag(input logic [15:0] raw);
      logic [16:0] v;
      v = 17'($signed(raw[AXIS_BITS-1:0]));
      return raw[AXIS_BITS-1] ? 16'(17'(-v)) : v[15:0];
   endfunction

   assign stick_xr = job_ff[1] ? rx_ff : lx_ff;
   assign stick_yr = job_ff[1] ? ry_ff : ly_ff;
   assign cur_raw  = job_ff[0] ? stick_yr : stick_xr;
   assign mag_x    = axis_mag(stick_xr);
   assign mag_y    = axis_mag(stick_yr);
   assign cur_mag  = job_ff[0] ? mag_y : mag_x;
   assign cur_neg  = cur_raw[AXIS_BITS-1];
   assign dzc      = 17'h10000 - 17'(dz_ff);

   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge   = ~diff[60];

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.pressed_edges       = o_prs_ff;
   assign rsp_chan.released_edges      = o_rel_ff;
   assign rsp_chan.held_buttons        = o_held_ff;
   assign rsp_chan.left_out_x          = o_lx_ff;
   assign rsp_chan.left_out_y          = o_ly_ff;
   assign rsp_chan.right_out_x         = o_rx_ff;
   assign rsp_chan.right_out_y         = o_ry_ff;
   assign rsp_chan.left_trigger_level  = o_lt_ff;
   assign rsp_chan.right_trigger_level = o_rt_ff;

   always_comb begin
      state_in = state_ff;  job_in = job_ff;  cnt_in = cnt_ff;
      thr_in = thr_ff;  thrsq_in = thrsq_ff;  acc_in = acc_ff;
      rem_in = rem_ff;  root_in = root_ff;  q_in = q_ff;
      scale_in = scale_ff;  dvs_in = dvs_ff;
      res_in = res_ff;
      prev_in = prev_ff;  prs_in = prs_ff;  rel_in = rel_ff;  held_in = held_ff;
      lx_in = lx_ff;  ly_in = ly_ff;  rx_in = rx_ff;  ry_in = ry_ff;
      lt_in = lt_ff;  rt_in = rt_ff;
      dz_in = dz_ff;  inv_in = inv_ff;
      rsp_valid_in = rsp_valid_ff;
      o_prs_in = o_prs_ff;  o_rel_in = o_rel_ff;  o_held_in = o_held_ff;
      o_lx_in = o_lx_ff;  o_ly_in = o_ly_ff;  o_rx_in = o_rx_ff;  o_ry_in = o_ry_ff;
      o_lt_in = o_lt_ff;  o_rt_in = o_rt_ff;
      mul_a = '0;  mul_b = '0;  sub_a = '0;  sub_b = '0;
      sumsq = '0;  bitv = '0;  r = '0;  lhs = '0;  off = '0;  cap = '0;  sc = '0;
      num = '0;  qfin = '0;  qc = '0;  tt = '0;  dz255 = '0;  tsel = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEAD_ZONE: dz_in  = csr_wdata;
            CSR_INVERT_LY: inv_in = csr_wdata[0];
            default:       dz_in  = dz_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               prs_in  = req_chan.buttons & ~prev_ff;
               rel_in  = prev_ff & ~req_chan.buttons;
               held_in = req_chan.buttons;
               prev_in = req_chan.buttons;
               lx_in = req_chan.left_x;   ly_in = req_chan.left_y;
               rx_in = req_chan.right_x;  ry_in = req_chan.right_y;
               lt_in = req_chan.left_trigger;
               rt_in = req_chan.right_trigger;
               job_in   = 3'd0;
               state_in = ST_DZ;
            end
         end
         ST_DZ: begin
            mul_a    = 32'(dz_ff);
            mul_b    = 32'(AXIS_FS);
            state_in = ST_DZSQ;
         end
         ST_DZSQ: begin
            thr_in   = prod_ff[30:0];
            mul_a    = prod_ff[31:0];
            mul_b    = prod_ff[31:0];
            state_in = ST_SQX;
         end
         ST_SQX: begin
            if (job_ff == 3'd0) begin
               thrsq_in = prod_ff[61:0];
            end
            mul_a    = 32'(mag_x);
            mul_b    = 32'(mag_x);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in   = 40'(prod_ff[31:0]);
            mul_a    = 32'(mag_y);
            mul_b    = 32'(mag_y);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sumsq = acc_ff[31:0] + prod_ff[31:0];
            if ({sumsq, 32'b0} <= {2'b0, thrsq_ff}) begin
               res_in[job_ff]        = '0;
               res_in[job_ff | 3'd1] = '0;
               job_in   = job_ff + 3'd2;
               state_in = (job_ff == 3'd2) ? ST_TRG : ST_SQX;
            end else begin
               rem_in   = 60'({sumsq, 16'b0});
               root_in  = '0;
               cnt_in   = 5'd23;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            bitv  = 48'd1 << {cnt_ff, 1'b0};
            sub_a = rem_ff;
            sub_b = 60'(root_ff + bitv);
            if (ge) begin
               rem_in  = diff[59:0];
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            r   = root_ff[23:0];
            lhs = {r, 16'b0};
            off = 40'({thr_ff, 8'b0});
            cap = {AXIS_FS, 24'b0} - off;
            if (r == '0 || lhs <= off) begin
               res_in[job_ff]        = '0;
               res_in[job_ff | 3'd1] = '0;
               job_in   = job_ff + 3'd2;
               state_in = (job_ff == 3'd2) ? ST_TRG : ST_SQX;
            end else begin
               sc       = lhs - off;
               scale_in = (sc > cap) ? cap : sc;
               mul_a    = 32'(r);
               mul_b    = 32'(dzc);
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            dvs_in   = {prod_ff[40:0], 1'b0};
            state_in = ST_MLO;
         end
         ST_MLO: begin
            mul_a    = 32'(cur_mag);
            mul_b    = 32'(scale_ff[23:0]);
            state_in = ST_MHI;
         end
         ST_MHI: begin
            acc_in   = prod_ff[39:0];
            mul_a    = 32'(cur_mag);
            mul_b    = 32'(scale_ff[39:24]);
            state_in = ST_NUM;
         end
         ST_NUM: begin
            num      = 60'(acc_ff) + (60'(prod_ff[31:0]) << 24);
            rem_in   = (num << 1) + 60'(dvs_ff >> 1);
            q_in     = '0;
            cnt_in   = 5'd16;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            sub_a = rem_ff;
            sub_b = 60'(dvs_ff) << cnt_ff;
            if (ge) begin
               rem_in       = diff[59:0];
               q_in[cnt_ff] = 1'b1;
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               qfin = {q_ff[16:1], ge};
               if (job_ff[2]) begin
                  res_in[job_ff] = (qfin > 17'd255) ? 16'd255 : 16'(qfin[7:0]);
               end else begin
                  qc = (qfin > 17'(AXIS_FS)) ? AXIS_FS : qfin[15:0];
                  res_in[job_ff] = cur_neg ? 16'(-qc) : qc;
               end
               job_in = job_ff + 3'd1;
               case (job_ff)
                  3'd0, 3'd2: state_in = ST_MLO;
                  3'd1:       state_in = ST_SQX;
                  3'd3, 3'd4: state_in = ST_TRG;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_TRG: begin
            tsel  = job_ff[0] ? rt_ff : lt_ff;
            tt    = {tsel, 16'b0};
            dz255 = {dz_ff, 8'b0} - 24'(dz_ff);
            if (tt <= dz255) begin
               res_in[job_ff] = '0;
               job_in   = job_ff + 3'd1;
               state_in = (job_ff == 3'd5) ? ST_DONE : ST_TRG;
            end else begin
               rem_in   = (60'(tt - dz255) << 1) + 60'(dzc);
               dvs_in   = 42'({dzc, 1'b0});
               q_in     = '0;
               cnt_in   = 5'd16;
               state_in = ST_DIV;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               o_prs_in  = prs_ff;
               o_rel_in  = rel_ff;
               o_held_in = held_ff;
               o_lx_in   = res_ff[0];
               o_ly_in   = inv_ff ? 16'(-res_ff[1]) : res_ff[1];
               o_rx_in   = res_ff[2];
               o_ry_in   = res_ff[3];
               o_lt_in   = res_ff[4][7:0];
               o_rt_in   = res_ff[5][7:0];
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= '0;
         cnt_ff       <= '0;
         prev_ff      <= '0;
         dz_ff        <= DEAD_ZONE_RESET;
         inv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         cnt_ff       <= cnt_in;
         prev_ff      <= prev_in;
         dz_ff        <= dz_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      thr_ff   <= thr_in;
      thrsq_ff <= thrsq_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      q_ff     <= q_in;
      scale_ff <= scale_in;
      dvs_ff   <= dvs_in;
      res_ff   <= res_in;
      prs_ff   <= prs_in;
      rel_ff   <= rel_in;
      held_ff  <= held_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      lt_ff    <= lt_in;
      rt_ff    <= rt_in;
      o_prs_ff  <= o_prs_in;
      o_rel_ff  <= o_rel_in;
      o_held_ff <= o_held_in;
      o_lx_ff   <= o_lx_in;
      o_ly_ff   <= o_ly_in;
      o_rx_ff   <= o_rx_in;
      o_ry_ff   <= o_ry_in;
      o_lt_ff   <= o_lt_in;
      o_rt_ff   <= o_rt_in;
   end

endmodule

// ===== dv/gic_frame_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_frame_if
// Bench-side wrapper notes: the channel interfaces come from the design; this
// file only collects the frame and result structs used by the bench.
// ----------------------------------------------------------------------------
package gic_tb_pkg;
   import gic_pkg::*;

   typedef struct packed {
      buttons_type buttons;
      axis_type    lx, ly, rx, ry;
      trigger_type lt, rt;
   } frame_type;

   typedef struct packed {
      buttons_type pressed, released, held;
      axis_type    lx, ly, rx, ry;
      trigger_type lt, rt;
   } conditioned_type;

endpackage

// ===== dv/gamepad_input_conditioner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_tb
// Drives raw controller frames through the conditioner under random
// back-pressure and several dead zone settings, predicts each conditioned
// frame in the bench and compares every result beat with the prediction.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_tb;
   import gic_pkg::*;
   import gic_tb_pkg::*;

   localparam longint FS = 32767;
   localparam int LIMIT = 3000000;

   class frame_scoreboard;
      logic [15:0]  dead_zone;
      bit           invert_ly;
      logic [15:0]  prev_buttons;
      conditioned_type pending[$];
      int           mismatches;
      int           checked;

      function new();
         dead_zone = DEAD_ZONE_RESET;
         invert_ly = 0;
         prev_buttons = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function longint root(longint n);
         longint r, b;
         r = 0;
         b = longint'(1) << 62;
         while (b > n) b = b >>> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >>> 1) + b;
            end else r = r >>> 1;
            b = b >>> 2;
         end
         return r;
      endfunction

      function axis_type axis_scale(longint v, longint s, longint d);
         longint a, q;
         a = v < 0 ? -v : v;
         q = (2 * a * s + d) / (2 * d);
         if (q > FS) q = FS;
         return axis_type'(v < 0 ? -q : q);
      endfunction

      function void stick(axis_type x, axis_type y, output axis_type ox,
                          output axis_type oy);
         longint sx, sy, sq, dz, thr, r, off, s, cap, d;
         sx = x;
         sy = y;
         dz = dead_zone;
         sq = sx * sx + sy * sy;
         thr = dz * FS;
         ox = 0;
         oy = 0;
         // shifted sum reaches 2^63 only at the corner; compare unsigned
         if ((unsigned'(64'(sq)) << 32) <= unsigned'(64'(thr * thr))) return;
         r = root(sq << 16);
         if (r == 0) return;
         off = 256 * FS * dz;
         if (65536 * r <= off) return;
         s = 65536 * r - off;
         cap = 256 * FS * (65536 - dz);
         if (s > cap) s = cap;
         d = r * (65536 - dz);
         ox = axis_scale(sx, s, d);
         oy = axis_scale(sy, s, d);
      endfunction

      function trigger_type trig(trigger_type t);
         longint n, d;
         if (longint'(t) * 65536 <= 255 * longint'(dead_zone)) return 0;
         n = longint'(t) * 65536 - 255 * longint'(dead_zone);
         d = 65536 - longint'(dead_zone);
         n = (2 * n + d) / (2 * d);
         return n > 255 ? 8'd255 : trigger_type'(n);
      endfunction

      function void note_frame(frame_type f);
         conditioned_type c;
         c.pressed = f.buttons & ~prev_buttons;
         c.released = prev_buttons & ~f.buttons;
         c.held = f.buttons;
         prev_buttons = f.buttons;
         stick(f.lx, f.ly, c.lx, c.ly);
         stick(f.rx, f.ry, c.rx, c.ry);
         if (invert_ly) c.ly = -c.ly;
         c.lt = trig(f.lt);
         c.rt = trig(f.rt);
         pending.push_back(c);
      endfunction

      function void check_result(conditioned_type a);
         conditioned_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %p\n          got %p", e, a);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   csr_index_type csr_index = CSR_DEAD_ZONE;
   logic [CSR_W-1:0] csr_wdata = 0;
   int send_idle = 0, recv_idle = 0, hold_off = 0;
   longint cycles = 0;
   int sent = 0;
   frame_scoreboard sb;

   gic_req_if req();
   gic_rsp_if rsp();

   gamepad_input_conditioner dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.buttons = 0;
      req.left_x = 0;
      req.left_y = 0;
      req.right_x = 0;
      req.right_y = 0;
      req.left_trigger = 0;
      req.right_trigger = 0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout");
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: sample at rising edge, ready changes at falling edge
   always @(posedge clock) begin
      conditioned_type a;
      if (!reset && rsp.valid && rsp.ready) begin
         a.pressed = rsp.pressed_edges;
         a.released = rsp.released_edges;
         a.held = rsp.held_buttons;
         a.lx = rsp.left_out_x;
         a.ly = rsp.left_out_y;
         a.rx = rsp.right_out_x;
         a.ry = rsp.right_out_y;
         a.lt = rsp.left_trigger_level;
         a.rt = rsp.right_trigger_level;
         sb.check_result(a);
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 0;
      end else rsp.ready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   function automatic axis_type rand_axis();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 0;
         3: return axis_type'($urandom_range(4000)) - 16'sd2000;
         default: return axis_type'($urandom());
      endcase
   endfunction

   function automatic trigger_type rand_trig();
      case ($urandom_range(3))
         0: return 8'd255;
         1: return 8'd0;
         default: return trigger_type'($urandom());
      endcase
   endfunction

   // valid stays up between beats unless the sender idles; drain drops it
   task automatic send_frame(frame_type f);
      if ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle) @(negedge clock);
      end
      req.valid <= 1;
      req.buttons <= f.buttons;
      req.left_x <= f.lx;
      req.left_y <= f.ly;
      req.right_x <= f.rx;
      req.right_y <= f.ry;
      req.left_trigger <= f.lt;
      req.right_trigger <= f.rt;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_frame(f);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random(int n);
      frame_type f;
      repeat (n) begin
         f.buttons = 16'($urandom());
         f.lx = rand_axis();
         f.ly = rand_axis();
         f.rx = rand_axis();
         f.ry = rand_axis();
         f.lt = rand_trig();
         f.rt = rand_trig();
         send_frame(f);
      end
   endtask

   task automatic drain();
      req.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] v);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      if (idx == CSR_DEAD_ZONE) sb.dead_zone = v;
      else sb.invert_ly = v[0];
      @(negedge clock);
   endtask

   task automatic directed();
      frame_type f;
      axis_type ax[6] = '{16'sh8000, 16'sh7fff, 0, -16'sd1, 16'sd1, 16'sd5000};
      trigger_type tv[6] = '{0, 255, 1, 51, 52, 128};
      for (int i = 0; i < 6; i++) begin
         f.buttons = (i % 2) ? 16'hffff : 16'h0000;
         f.lx = ax[i];
         f.ly = ax[5 - i];
         f.rx = ax[(i + 2) % 6];
         f.ry = ax[i];
         f.lt = tv[i];
         f.rt = tv[5 - i];
         send_frame(f);
      end
      f.buttons = 16'h00ff; f.lx = 16'sh8000; f.ly = 16'sh8000;
      f.rx = 16'sh7fff; f.ry = 16'sh7fff; f.lt = 8'd255; f.rt = 8'd0;
      send_frame(f);
      f.buttons = 16'hff00; f.lx = 16'sd9000; f.ly = -16'sd1000;
      send_frame(f);
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      directed();
      drain();
      write_csr(CSR_INVERT_LY, 16'd1);
      directed();
      drain();
      write_csr(CSR_DEAD_ZONE, 16'd0);
      directed();
      drain();
      write_csr(CSR_DEAD_ZONE, 16'hffff);
      directed();
      drain();

      send_idle = 23; recv_idle = 69;
      write_csr(CSR_DEAD_ZONE, 16'd13107);
      write_csr(CSR_INVERT_LY, 16'd0);
      send_random(350);
      // long receiver stall while frames keep coming
      hold_off = 2000;
      send_random(20);
      drain();

      send_idle = 69; recv_idle = 23;
      write_csr(CSR_DEAD_ZONE, 16'd500);
      write_csr(CSR_INVERT_LY, 16'd1);
      send_random(300);
      drain();

      send_idle = 0; recv_idle = 0;
      write_csr(CSR_DEAD_ZONE, 16'($urandom()));
      send_random(250);
      drain();
      write_csr(CSR_DEAD_ZONE, 16'hffff);
      write_csr(CSR_INVERT_LY, 16'd0);
      send_random(150);
      drain();
      write_csr(CSR_DEAD_ZONE, 16'd0);
      send_random(150);
      drain();

      $display("%0d frames sent, %0d results checked over several dead zone and",
               sent, sb.checked);
      $display("inversion settings with random back-pressure.");
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("All tests passed");
      else begin
         $display("%0d mismatches, %0d missing", sb.mismatches, sb.pending.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
